[rtl/core/mcms_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mcms_pkg;

  // parser phases within a composition data message
  typedef enum logic [2:0] {
    PH_HEADER   = 3'd0,
    PH_LOCATION = 3'd1,
    PH_SIGCNT   = 3'd2,
    PH_VENDCNT  = 3'd3,
    PH_MODEL_LO = 3'd4,
    PH_MODEL_HI = 3'd5,
    PH_VENDOR   = 3'd6
  } phase_e;

  localparam int unsigned SkipW    = 10;
  localparam int unsigned HeaderW  = 4;

  localparam logic [HeaderW-1:0] HeaderBytes    = 4'd10;
  localparam logic [SkipW-1:0]   LocationBytes  = 10'd2;
  localparam logic [15:0]        IdOnoff        = 16'h1000;
  localparam logic [15:0]        IdLevel        = 16'h1002;

endpackage

`default_nettype wire

[rtl/core/mesh_composition_model_scanner_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Composition data (page 0) model scanner.
// Input channel: one message byte per transfer (data_byte_i), with last_byte_i
// set on the final byte. Header, element locations and vendor models are
// skipped; each complete SIG model id is compared against generic on/off
// (0x1000) and generic level (0x1002).
// Output channel: one result transfer per message, taken from the final byte:
// onoff_found_o, level_found_o and too_short_o (fewer than ten bytes, with
// both found flags then cleared).
// Throughput is one byte per cycle: each byte is a single small state update
// in the parser registers. The result appears in the cycle after the final
// byte transfer, from the output register.
// While a result waits in the output register and the receiver stalls, the
// input channel stalls too; otherwise a new byte is taken in every cycle, also
// in the cycle in which a waiting result is taken.
// Reset clears the parser to the start of a message and empties the output
// register; after each final byte the parser returns to that same state.
module mesh_composition_model_scanner_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       last_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            onoff_found_o,
  output logic            level_found_o,
  output logic            too_short_o
);

  localparam int unsigned SkipW   = mcms_pkg::SkipW;
  localparam int unsigned HeaderW = mcms_pkg::HeaderW;

  mcms_pkg::phase_e     phase_q, phase_d;
  logic [SkipW-1:0]     skip_count_q, skip_count_d;
  logic [7:0]           sig_left_q, sig_left_d;
  logic [7:0]           vendor_count_q, vendor_count_d;
  logic [7:0]           model_low_q, model_low_d;
  logic                 onoff_seen_q, onoff_seen_d;
  logic                 level_seen_q, level_seen_d;
  logic [HeaderW-1:0]   header_seen_q, header_seen_d;

  logic                 out_valid_q;
  logic                 onoff_found_q, level_found_q, too_short_q;
  logic                 res_onoff, res_level, res_short;

  logic                 in_xfer;
  logic                 out_free;

  // handshake: the output register frees up when empty or being taken
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !out_free;
  assign in_xfer    = in_valid_i && out_free;

  // parser next state for the byte on the input
  always_comb begin
    logic [SkipW-1:0] skip_dec;
    logic [15:0]      sig_id;
    logic             pick_next;

    phase_d        = phase_q;
    skip_count_d   = skip_count_q;
    sig_left_d     = sig_left_q;
    vendor_count_d = vendor_count_q;
    model_low_d    = model_low_q;
    onoff_seen_d   = onoff_seen_q;
    level_seen_d   = level_seen_q;
    header_seen_d  = header_seen_q;
    pick_next      = 1'b0;

    skip_dec = (skip_count_q != '0) ? skip_count_q - SkipW'(1) : skip_count_q;
    sig_id   = {data_byte_i, model_low_q};

    case (phase_q)
      mcms_pkg::PH_HEADER: begin
        header_seen_d = header_seen_q + HeaderW'(1);
        if (header_seen_d >= mcms_pkg::HeaderBytes) begin
          header_seen_d = mcms_pkg::HeaderBytes;
          phase_d       = mcms_pkg::PH_LOCATION;
          skip_count_d  = mcms_pkg::LocationBytes;
        end
      end
      mcms_pkg::PH_LOCATION: begin
        skip_count_d = skip_dec;
        if (skip_dec == '0) begin
          phase_d = mcms_pkg::PH_SIGCNT;
        end
      end
      mcms_pkg::PH_SIGCNT: begin
        sig_left_d = data_byte_i;
        phase_d    = mcms_pkg::PH_VENDCNT;
      end
      mcms_pkg::PH_VENDCNT: begin
        vendor_count_d = data_byte_i;
        pick_next      = 1'b1;
      end
      mcms_pkg::PH_MODEL_LO: begin
        model_low_d = data_byte_i;
        phase_d     = mcms_pkg::PH_MODEL_HI;
      end
      mcms_pkg::PH_MODEL_HI: begin
        if (sig_id == mcms_pkg::IdOnoff) begin
          onoff_seen_d = 1'b1;
        end else if (sig_id == mcms_pkg::IdLevel) begin
          level_seen_d = 1'b1;
        end
        if (sig_left_q != '0) begin
          sig_left_d = sig_left_q - 8'd1;
        end
        pick_next = 1'b1;
      end
      mcms_pkg::PH_VENDOR: begin
        skip_count_d = skip_dec;
        if (skip_dec == '0) begin
          phase_d      = mcms_pkg::PH_LOCATION;
          skip_count_d = mcms_pkg::LocationBytes;
        end
      end
      default: begin
        phase_d      = mcms_pkg::PH_LOCATION;
        skip_count_d = mcms_pkg::LocationBytes;
      end
    endcase

    // after the counts or a model id: models, vendor area or next element
    if (pick_next) begin
      if (sig_left_d != '0) begin
        phase_d = mcms_pkg::PH_MODEL_LO;
      end else if (vendor_count_d != '0) begin
        phase_d      = mcms_pkg::PH_VENDOR;
        skip_count_d = {vendor_count_d, 2'b00};
      end else begin
        phase_d      = mcms_pkg::PH_LOCATION;
        skip_count_d = mcms_pkg::LocationBytes;
      end
    end
  end

  // result of the final byte
  assign res_short = header_seen_d < mcms_pkg::HeaderBytes;
  assign res_onoff = !res_short && onoff_seen_d;
  assign res_level = !res_short && level_seen_d;

  // parser registers, back to the message start after the final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= mcms_pkg::PH_HEADER;
      skip_count_q   <= '0;
      sig_left_q     <= '0;
      vendor_count_q <= '0;
      model_low_q    <= '0;
      onoff_seen_q   <= 1'b0;
      level_seen_q   <= 1'b0;
      header_seen_q  <= '0;
    end else if (in_xfer) begin
      if (last_byte_i) begin
        phase_q        <= mcms_pkg::PH_HEADER;
        skip_count_q   <= '0;
        sig_left_q     <= '0;
        vendor_count_q <= '0;
        model_low_q    <= '0;
        onoff_seen_q   <= 1'b0;
        level_seen_q   <= 1'b0;
        header_seen_q  <= '0;
      end else begin
        phase_q        <= phase_d;
        skip_count_q   <= skip_count_d;
        sig_left_q     <= sig_left_d;
        vendor_count_q <= vendor_count_d;
        model_low_q    <= model_low_d;
        onoff_seen_q   <= onoff_seen_d;
        level_seen_q   <= level_seen_d;
        header_seen_q  <= header_seen_d;
      end
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_xfer && last_byte_i;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (in_xfer && last_byte_i) begin
      onoff_found_q <= res_onoff;
      level_found_q <= res_level;
      too_short_q   <= res_short;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign onoff_found_o = onoff_found_q;
  assign level_found_o = level_found_q;
  assign too_short_o   = too_short_q;

  // checks on the parser and result logic
  a_short_clears_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && too_short_q |-> !onoff_found_q && !level_found_q)
    else $error("short message reported with a model flag");

  a_header_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    header_seen_q <= mcms_pkg::HeaderBytes)
    else $error("header byte count beyond ten");

  a_header_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != mcms_pkg::PH_HEADER |-> header_seen_q == mcms_pkg::HeaderBytes)
    else $error("element parsing before the header is complete");

  a_final_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && last_byte_i |=> out_valid_q)
    else $error("final byte transfer gave no result");

  a_location_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == mcms_pkg::PH_LOCATION |-> skip_count_q <= mcms_pkg::LocationBytes
      && skip_count_q != '0)
    else $error("location skip count out of range");

endmodule

`default_nettype wire
